### hw/rtl/lrws_pkg.sv
// Package with the state, action and direction codes of the lattice random walk core.
`timescale 1ns / 1ps
`default_nettype none
package lrws_pkg;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_INC
  } state_e;

  // Action codes of an input transaction.
  typedef enum logic [1:0] {
    ACT_PLACE = 2'd0,
    ACT_MOVE  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  // Move directions.
  localparam logic [1:0] DIR_YM = 2'd0;
  localparam logic [1:0] DIR_XP = 2'd1;
  localparam logic [1:0] DIR_XM = 2'd2;
  localparam logic [1:0] DIR_YP = 2'd3;

  localparam int unsigned CfgWidth   = 15;
  localparam logic [14:0] CfgReset   = 15'd8192;
  localparam int unsigned CountOutW  = 13;

endpackage
`default_nettype wire

### hw/rtl/lattice_random_walk_step_core.sv
// Top level of the lattice random walk core: two count banks with a scanning sequencer.
// Place, read and no-op transactions pass through the execute state, which registers their result.
// A move scans site by site from the scan position until it finds an occupied site, then updates
// the destination site in the increment state; the end of a sweep scans each remaining empty site.
// The scan rate is one site per cycle, set by the single read port of the current bank.
// After reset a clearing pass over all GRID_SIDE*GRID_SIDE sites zeroes both banks; busy is high.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module lattice_random_walk_step_core #(
  parameter int unsigned GRID_SIDE     = 256,
  parameter int unsigned MAX_PARTICLES = 4096,
  parameter int unsigned RANDOM_BITS   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] site_index_i,
  input  wire logic [15:0] random_draw_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [14:0] cfg_data_i,
  output logic             result_valid_o,
  output logic [12:0]      site_count_o,
  output logic             place_accepted_o,
  output logic             moved_o,
  output logic [15:0]      from_index_o,
  output logic [1:0]       direction_o,
  output logic             sweep_done_o
);

  localparam int unsigned Sites = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW    = $clog2(Sites);
  localparam int unsigned XW    = $clog2(GRID_SIDE);
  localparam int unsigned CW    = $clog2(MAX_PARTICLES + 1);
  localparam logic [AW-1:0] LastSite = AW'(Sites - 1);
  localparam logic [AW-1:0] SideA    = AW'(GRID_SIDE);
  localparam logic [AW-1:0] SideM1   = AW'(GRID_SIDE - 1);
  localparam logic [AW-1:0] WrapY    = AW'((GRID_SIDE - 1) * GRID_SIDE);
  localparam logic [XW-1:0] XLast    = XW'(GRID_SIDE - 1);
  localparam logic [15:0]   RMask    = (RANDOM_BITS >= 16) ? 16'hFFFF
                                       : 16'((64'd1 << RANDOM_BITS) - 64'd1);
  localparam logic [33:0]   Quarter  = 34'(64'd1 << (RANDOM_BITS - 2));

  lrws_pkg::state_e state_q, state_d;

  logic          active_q;
  logic [AW-1:0] scan_q, scan_d;
  logic [XW-1:0] x_q, y_q;
  logic [CW-1:0] total_q;
  logic [14:0]   thr_q;
  logic [AW-1:0] clr_q;
  logic [1:0]    action_q;
  logic [AW-1:0] site_q;
  logic          inrange_q;
  logic [15:0]   draw_q;
  logic [AW-1:0] dst_q, dst_d;
  logic [1:0]    dir_q, dir_d;

  logic [31:0]   site_w;
  logic [AW-1:0] site_addr;
  logic          site_in;

  // Bank ports seen as current and next.
  logic          cur_we, nxt_we;
  logic [AW-1:0] cur_waddr, nxt_waddr, cur_raddr, nxt_raddr;
  logic [CW-1:0] cur_wdata, nxt_wdata, cur_rd, nxt_rd;
  logic          a_we, b_we;
  logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [CW-1:0] a_wdata, b_wdata, a_rd, b_rd;

  logic          place_ok, found, accept;
  logic [33:0]   draw_m, t1, t2;
  logic [31:0]   cnt_w;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != lrws_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign site_w      = {16'd0, site_index_i};
  assign site_addr   = site_w[AW-1:0];
  assign site_in     = site_w < Sites;

  assign found    = (cur_rd != '0);
  assign place_ok = inrange_q && (cur_rd == '0) && (nxt_rd == '0) &&
                    (32'(total_q) < MAX_PARTICLES);
  assign cnt_w    = 32'(cur_rd);

  // Direction choice from the draw and the move threshold.
  assign draw_m = {18'd0, draw_q & RMask};
  assign t1     = Quarter + 34'(thr_q);
  assign t2     = t1 + 34'(thr_q);
  always_comb begin
    if (draw_m < Quarter) begin
      dir_d = lrws_pkg::DIR_YM;
    end else if (draw_m < t1) begin
      dir_d = lrws_pkg::DIR_XP;
    end else if (draw_m < t2) begin
      dir_d = lrws_pkg::DIR_XM;
    end else begin
      dir_d = lrws_pkg::DIR_YP;
    end
  end

  // Neighbor site on the torus from the tracked coordinates.
  always_comb begin
    unique case (dir_d)
      lrws_pkg::DIR_YM: dst_d = (y_q == '0) ? scan_q + WrapY : scan_q - SideA;
      lrws_pkg::DIR_XP: dst_d = (x_q == XLast) ? scan_q - SideM1 : scan_q + 1'b1;
      lrws_pkg::DIR_XM: dst_d = (x_q == '0) ? scan_q + SideM1 : scan_q - 1'b1;
      default:          dst_d = (y_q == XLast) ? scan_q - WrapY : scan_q + SideA;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrws_pkg::ST_CLEAR: if (clr_q == LastSite) state_d = lrws_pkg::ST_IDLE;
      lrws_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (action_i == lrws_pkg::ACT_MOVE) ? lrws_pkg::ST_SCAN
                                                     : lrws_pkg::ST_EXEC;
        end
      end
      lrws_pkg::ST_EXEC: state_d = lrws_pkg::ST_IDLE;
      lrws_pkg::ST_SCAN: begin
        if (found) begin
          state_d = lrws_pkg::ST_INC;
        end else if (scan_q == LastSite) begin
          state_d = lrws_pkg::ST_IDLE;
        end
      end
      lrws_pkg::ST_INC: state_d = lrws_pkg::ST_IDLE;
      default: state_d = lrws_pkg::ST_IDLE;
    endcase
  end

  // Memory controls for each state.
  always_comb begin
    cur_we    = 1'b0;
    nxt_we    = 1'b0;
    cur_waddr = site_q;
    nxt_waddr = site_q;
    cur_wdata = CW'(1);
    nxt_wdata = CW'(1);
    cur_raddr = site_addr;
    nxt_raddr = site_addr;
    scan_d    = scan_q + 1'b1;
    unique case (state_q)
      lrws_pkg::ST_CLEAR: begin
        cur_we    = 1'b1;
        nxt_we    = 1'b1;
        cur_waddr = clr_q;
        nxt_waddr = clr_q;
        cur_wdata = '0;
        nxt_wdata = '0;
      end
      lrws_pkg::ST_IDLE: begin
        if (action_i == lrws_pkg::ACT_MOVE) cur_raddr = scan_q;
      end
      lrws_pkg::ST_EXEC: begin
        if (action_q == lrws_pkg::ACT_PLACE && place_ok) begin
          if (site_q >= scan_q) cur_we = 1'b1;
          else nxt_we = 1'b1;
        end
      end
      lrws_pkg::ST_SCAN: begin
        cur_raddr = scan_d;
        if (found) begin
          cur_we    = 1'b1;
          cur_waddr = scan_q;
          cur_wdata = cur_rd - 1'b1;
          nxt_raddr = dst_d;
        end
      end
      lrws_pkg::ST_INC: begin
        nxt_we    = 1'b1;
        nxt_waddr = dst_q;
        nxt_wdata = nxt_rd + 1'b1;
      end
      default: ;
    endcase
  end

  // Bank swap between physical memories.
  assign a_we    = active_q ? nxt_we : cur_we;
  assign a_waddr = active_q ? nxt_waddr : cur_waddr;
  assign a_wdata = active_q ? nxt_wdata : cur_wdata;
  assign a_raddr = active_q ? nxt_raddr : cur_raddr;
  assign b_we    = active_q ? cur_we : nxt_we;
  assign b_waddr = active_q ? cur_waddr : nxt_waddr;
  assign b_wdata = active_q ? cur_wdata : nxt_wdata;
  assign b_raddr = active_q ? cur_raddr : nxt_raddr;
  assign cur_rd  = active_q ? b_rd : a_rd;
  assign nxt_rd  = active_q ? a_rd : b_rd;

  lrws_ram #(.Width(CW), .Depth(Sites)) u_bank_a (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rd)
  );

  lrws_ram #(.Width(CW), .Depth(Sites)) u_bank_b (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(b_raddr), .rdata_o(b_rd)
  );

  // Control registers and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= lrws_pkg::ST_CLEAR;
      active_q       <= 1'b0;
      scan_q         <= '0;
      x_q            <= '0;
      y_q            <= '0;
      total_q        <= '0;
      thr_q          <= lrws_pkg::CfgReset;
      clr_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) thr_q <= cfg_data_i;
      if (state_q == lrws_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == lrws_pkg::ST_EXEC) begin
        result_valid_o <= 1'b1;
        if (action_q == lrws_pkg::ACT_PLACE && place_ok) total_q <= total_q + 1'b1;
      end
      if (state_q == lrws_pkg::ST_INC) result_valid_o <= 1'b1;
      if (state_q == lrws_pkg::ST_SCAN && !found) begin
        if (scan_q == LastSite) begin
          active_q       <= !active_q;
          scan_q         <= '0;
          x_q            <= '0;
          y_q            <= '0;
          result_valid_o <= 1'b1;
        end else begin
          scan_q <= scan_d;
          if (x_q == XLast) begin
            x_q <= '0;
            y_q <= y_q + 1'b1;
          end else begin
            x_q <= x_q + 1'b1;
          end
        end
      end
    end
  end

  // Transaction payload and result fields.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q  <= action_i;
      site_q    <= site_addr;
      inrange_q <= site_in;
      draw_q    <= random_draw_i;
    end
    if (state_q == lrws_pkg::ST_SCAN && found) begin
      dst_q <= dst_d;
      dir_q <= dir_d;
    end
    site_count_o     <= '0;
    place_accepted_o <= 1'b0;
    moved_o          <= 1'b0;
    from_index_o     <= '0;
    direction_o      <= '0;
    sweep_done_o     <= 1'b0;
    if (state_q == lrws_pkg::ST_EXEC) begin
      if (action_q == lrws_pkg::ACT_READ && inrange_q) site_count_o <= cnt_w[12:0];
      place_accepted_o <= (action_q == lrws_pkg::ACT_PLACE) && place_ok;
    end
    if (state_q == lrws_pkg::ST_SCAN && !found && scan_q == LastSite) sweep_done_o <= 1'b1;
    if (state_q == lrws_pkg::ST_INC) begin
      moved_o      <= 1'b1;
      from_index_o <= 16'(32'(scan_q));
      direction_o  <= dir_q;
    end
  end

  // A result reports a move or a sweep end, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(moved_o && sweep_done_o))
    else $error("move and sweep end reported together");

  // The destination update always produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lrws_pkg::ST_INC) |=> (result_valid_o && moved_o))
    else $error("move result missing");

  // The particle total never exceeds capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= MAX_PARTICLES)
    else $error("particle total over capacity");

  // A sweep end returns the scan position to the first site.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && sweep_done_o) |-> (scan_q == '0))
    else $error("scan position not reset at sweep end");

endmodule
`default_nettype wire

### hw/rtl/lrws_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lrws_ram #(
  parameter int unsigned Width = 13,
  parameter int unsigned Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
